// ----- sv/obdrfp_pkg.sv -----
// Shared types and constants of the diagnostic response frame parser.
package obdrfp_pkg;

	localparam int BUF_DEPTH = 64;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int LEN_W     = $clog2(BUF_DEPTH + 1);
	localparam int IDX_W     = $clog2(BUF_DEPTH + 2);
	localparam int CNT_W     = (IDX_W > 12) ? IDX_W : 12;
	localparam int OUT_LIMIT = 32;
	localparam int OUT_W     = 6;

	localparam logic [7:0] SVC_NACK      = 8'h7f;
	localparam logic [8:0] SVC_REPLY_OFS = 9'h040;
	localparam logic [7:0] HI_MASK       = 8'hf0;
	localparam logic [7:0] LO_MASK       = 8'h0f;
	localparam logic [7:0] FMT_LEN_MASK  = 8'h3f;
	localparam logic [7:0] FMT_ADDR_BIT  = 8'h80;
	localparam logic [7:0] PCI_SINGLE    = 8'h00;
	localparam logic [7:0] PCI_FIRST     = 8'h10;
	localparam logic [7:0] MODE_CUR_DATA = 8'h01;
	localparam logic [7:0] MODE_DTC      = 8'h03;

	typedef enum logic [1:0] {
		CFG_HEADER_KIND  = 2'd0,
		CFG_REQUEST_MODE = 2'd1,
		CFG_REQUEST_PID  = 2'd2,
		CFG_MAX_OUT      = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_RESP   = 3'd1,
		ST_BAD_LEN   = 3'd2,
		ST_NACK      = 3'd3,
		ST_WRONG_SVC = 3'd4,
		ST_WRONG_PID = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             data_valid;
		logic [2:0]       status;
		logic [7:0]       detail;
		logic [OUT_W-1:0] byte_count;
		logic [31:0]      packed_value;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic             header_kind;
		logic [7:0]       request_mode;
		logic [7:0]       request_pid;
		logic [OUT_W-1:0] max_out;
	} cfg_t;

	typedef struct packed {
		logic             go;
		logic [IDX_W-1:0] n;
		logic             ovf;
	} start_t;

	typedef struct packed {
		logic              en;
		logic [BUF_AW-1:0] addr;
	} rd_req_t;

endpackage

// ----- sv/obdrfp_buf.sv -----
// Message byte store: one write port, one registered read port.
module obdrfp_buf (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [obdrfp_pkg::BUF_AW-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	input  obdrfp_pkg::rd_req_t      rd,
	output logic [7:0]               rd_data
);
	import obdrfp_pkg::*;

	logic [7:0] mem [BUF_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/obdrfp_seq.sv -----
// Parse sequencer: header checks, payload walk and result word register.
module obdrfp_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  obdrfp_pkg::cfg_t      cfg,
	input  obdrfp_pkg::start_t    start,
	output logic                  idle,
	output obdrfp_pkg::rd_req_t   rd,
	input  logic [7:0]            rd_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output obdrfp_pkg::out_item_t out_data
);
	import obdrfp_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_START = 12'b0000_0000_0010,
		S_FMT   = 12'b0000_0000_0100,
		S_CHK   = 12'b0000_0000_1000,
		S_SVC   = 12'b0000_0001_0000,
		S_NACK  = 12'b0000_0010_0000,
		S_PID   = 12'b0000_0100_0000,
		S_WALK  = 12'b0000_1000_0000,
		S_DAT   = 12'b0001_0000_0000,
		S_FF    = 12'b0010_0000_0000,
		S_ERR   = 12'b0100_0000_0000,
		S_FIN   = 12'b1000_0000_0000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] n_q;
	logic             ovf_q;
	logic [2:0]       hs_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] vend_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OUT_W-1:0] outc_q;
	logic [31:0]      packed_q;
	logic [7:0]       pend_q;
	logic [3:0]       ff_hi_q;
	status_t          err_status_q;
	logic [7:0]       err_detail_q;
	logic             zero_q;
	out_item_t        out_q;
	logic             out_valid_q;

	logic [IDX_W-1:0] rd_idx;
	logic [7:0]       cur;
	logic             slot_free;
	logic             emit;
	out_item_t        emit_item;
	logic [OUT_W-1:0] limit;
	logic [IDX_W-1:0] hs_x;
	logic [IDX_W-1:0] need;
	logic [2:0]       fmt_hs;
	logic             svc_match;
	logic             take_byte;

	assign cur       = zero_q ? 8'h00 : rd_data;
	assign slot_free = !out_valid_q || out_ready;
	assign limit     = (cfg.max_out > OUT_W'(OUT_LIMIT)) ? OUT_W'(OUT_LIMIT) : cfg.max_out;
	assign hs_x      = IDX_W'(hs_q);
	assign idle      = (state_q == S_IDLE);

	assign fmt_hs = 3'd1 + (((cur & FMT_ADDR_BIT) != 8'h00) ? 3'd2 : 3'd0)
		+ (((cur & FMT_LEN_MASK) == 8'h00) ? 3'd1 : 3'd0);

	always_comb begin
		if (cfg.request_mode == MODE_DTC) begin
			need = hs_x + IDX_W'(1);
		end else if (cfg.request_pid != 8'h00) begin
			need = hs_x + IDX_W'(3);
		end else begin
			need = hs_x + IDX_W'(2);
		end
	end

	// reply service is compared at nine bits, so modes above 0xbf never match
	assign svc_match = ({1'b0, cur} == (SVC_REPLY_OFS + {1'b0, cfg.request_mode}));

	// a payload byte is taken once the previous one can be pushed out
	assign take_byte = (cnt_q != '0) && (outc_q < limit) && ((outc_q == '0) || slot_free);

	// read requests to the store
	always_comb begin
		rd_idx = '0;
		rd.en  = 1'b0;
		case (state_q)
			S_START: begin
				rd.en = 1'b1;
			end
			S_CHK: begin
				rd_idx = hs_x;
				rd.en  = 1'b1;
			end
			S_SVC: begin
				rd_idx = (cur == SVC_NACK) ? hs_x + IDX_W'(2) : hs_x + IDX_W'(1);
				rd.en  = 1'b1;
			end
			S_WALK: begin
				rd_idx = i_q;
				rd.en  = 1'b1;
			end
			S_DAT: begin
				rd_idx = i_q + IDX_W'(1);
				rd.en  = (cnt_q == '0) && ((cur & HI_MASK) == PCI_FIRST);
			end
			default: begin
				rd_idx = '0;
				rd.en  = 1'b0;
			end
		endcase
		rd.addr = rd_idx[BUF_AW-1:0];
	end

	// result word to be emitted
	always_comb begin
		emit      = 1'b0;
		emit_item = '0;
		case (state_q)
			S_DAT: begin
				emit                 = take_byte && (outc_q != '0);
				emit_item.data_byte  = pend_q;
				emit_item.data_valid = 1'b1;
			end
			S_ERR: begin
				emit                 = 1'b1;
				emit_item.status     = err_status_q;
				emit_item.detail     = err_detail_q;
				emit_item.last       = 1'b1;
			end
			S_FIN: begin
				emit                   = 1'b1;
				emit_item.data_byte    = (outc_q != '0) ? pend_q : 8'h00;
				emit_item.data_valid   = (outc_q != '0);
				emit_item.byte_count   = outc_q;
				emit_item.packed_value = packed_q;
				emit_item.last         = 1'b1;
			end
			default: begin
				emit      = 1'b0;
				emit_item = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && slot_free) begin
			out_q <= emit_item;
		end
		if (rd.en) begin
			zero_q <= (rd_idx >= n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start.go) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (ovf_q || n_q < IDX_W'(3)) begin
						state_q <= S_ERR;
					end else if (!cfg.header_kind) begin
						state_q <= S_CHK;
					end else begin
						state_q <= S_FMT;
					end
				end
				S_FMT: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= (n_q < need) ? S_ERR : S_SVC;
				end
				S_SVC: begin
					if (cur == SVC_NACK) begin
						state_q <= S_NACK;
					end else if (!svc_match) begin
						state_q <= S_ERR;
					end else if (cfg.request_mode == MODE_CUR_DATA) begin
						state_q <= S_PID;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_NACK: begin
					state_q <= S_ERR;
				end
				S_PID: begin
					state_q <= (cur != cfg.request_pid) ? S_ERR : S_WALK;
				end
				S_WALK: begin
					state_q <= (i_q >= vend_q) ? S_FIN : S_DAT;
				end
				S_DAT: begin
					if (cnt_q != '0) begin
						if (outc_q >= limit) begin
							state_q <= S_FIN;
						end else if (take_byte) begin
							state_q <= S_WALK;
						end
					end else if ((cur & HI_MASK) == PCI_FIRST) begin
						state_q <= S_FF;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_FF: begin
					state_q <= S_WALK;
				end
				S_ERR, S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q      <= start.n;
				ovf_q    <= start.ovf;
				outc_q   <= '0;
				packed_q <= '0;
				hs_q     <= 3'd3;
			end
			S_START: begin
				err_status_q <= (!ovf_q && n_q == '0) ? ST_NO_RESP : ST_BAD_LEN;
				err_detail_q <= 8'h00;
			end
			S_FMT: begin
				hs_q <= fmt_hs;
			end
			S_CHK: begin
				err_status_q <= ST_BAD_LEN;
				err_detail_q <= 8'h00;
			end
			S_SVC: begin
				err_status_q <= ST_WRONG_SVC;
				err_detail_q <= cur;
				i_q          <= hs_x + IDX_W'(1);
				if (cfg.request_mode == MODE_DTC) begin
					vend_q <= n_q;
					cnt_q  <= CNT_W'(n_q - hs_x - IDX_W'(1));
				end else begin
					vend_q <= n_q - IDX_W'(1);
					cnt_q  <= CNT_W'(n_q - hs_x - IDX_W'(2));
				end
			end
			S_NACK: begin
				err_status_q <= ST_NACK;
				err_detail_q <= cur;
			end
			S_PID: begin
				err_status_q <= ST_WRONG_PID;
				err_detail_q <= cur;
				i_q          <= i_q + IDX_W'(1);
			end
			S_DAT: begin
				if (cnt_q != '0) begin
					if (take_byte) begin
						pend_q <= cur;
						outc_q <= outc_q + OUT_W'(1);
						cnt_q  <= cnt_q - CNT_W'(1);
						i_q    <= i_q + IDX_W'(1);
						if (outc_q < OUT_W'(4)) begin
							packed_q <= {packed_q[23:0], cur};
						end
					end
				end else begin
					ff_hi_q <= cur[3:0];
					if ((cur & HI_MASK) == PCI_SINGLE) begin
						cnt_q <= CNT_W'(cur & LO_MASK);
						i_q   <= i_q + IDX_W'(1);
					end else if ((cur & HI_MASK) != PCI_FIRST) begin
						i_q <= i_q + IDX_W'(1);
					end
				end
			end
			S_FF: begin
				cnt_q <= CNT_W'({ff_hi_q, cur});
				i_q   <= i_q + IDX_W'(2);
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- sv/obd_response_frame_parser.sv -----
// Diagnostic response frame parser: takes the bytes of one received OBD message (ISO 9141 or
// KWP header) and, at end of message, checks it and delivers its payload bytes one word each.
// Byte words are taken only while the parser is idle. At end of message the block runs the
// header checks, walks the payload bytes one at a time (with an extra step for a first-frame
// length header) and emits the result word, all through the single read port of the 64-byte
// message store; output stalls hold the walk and no input is taken meanwhile.
// A final result word may wait on the output while the next message is loaded. There is no
// clearing pass after reset.
module obd_response_frame_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  obdrfp_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output obdrfp_pkg::out_item_t out_data,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [7:0]            cfg_wdata
);
	import obdrfp_pkg::*;

	cfg_t             cfg_q;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             idle;
	logic             acc;
	logic             room;
	logic             wr_en;
	start_t           start;
	rd_req_t          rd;
	logic [7:0]       rd_data;

	assign acc   = in_valid && in_ready;
	assign room  = (len_q < LEN_W'(BUF_DEPTH));
	assign wr_en = acc && in_data.has_byte && room;

	assign start.go  = acc && in_data.end_of_message;
	assign start.n   = IDX_W'(len_q) + IDX_W'(wr_en);
	assign start.ovf = ovf_q || (in_data.has_byte && !room);

	assign in_ready = idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_kind  <= 1'b0;
			cfg_q.request_mode <= 8'h01;
			cfg_q.request_pid  <= 8'h00;
			cfg_q.max_out      <= OUT_W'(4);
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_HEADER_KIND:  cfg_q.header_kind  <= cfg_wdata[0];
				CFG_REQUEST_MODE: cfg_q.request_mode <= cfg_wdata;
				CFG_REQUEST_PID:  cfg_q.request_pid  <= cfg_wdata;
				CFG_MAX_OUT:      cfg_q.max_out      <= cfg_wdata[OUT_W-1:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	// fill level and overflow of the current message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (acc) begin
			if (in_data.end_of_message) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (in_data.has_byte) begin
				if (room) begin
					len_q <= len_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	obdrfp_buf u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (len_q[BUF_AW-1:0]),
		.wr_data (in_data.rx_byte),
		.rd      (rd),
		.rd_data (rd_data)
	);

	obdrfp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.idle      (idle),
		.rd        (rd),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
